// ----- hw/rtl/vfm_pkg.sv -----
// Shared types, constants and corner geometry for the voxel face mesher.
package vfm_pkg;

  // Field widths fixed by the item format
  localparam int NUM_W   = 12;
  localparam int VN_W    = 17;
  localparam int FACE_W  = 3;
  localparam int CORN_W  = 2;
  localparam int POS_W   = 7;
  localparam int COL_W   = 2;
  localparam int NUM_FACES = 6;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_MESH  = 1'b1;

  // Map row read selectors: center row, then the four row neighbors
  typedef logic [2:0] sel_t;
  localparam sel_t SEL_C  = 3'd0;
  localparam sel_t SEL_XP = 3'd1;
  localparam sel_t SEL_XM = 3'd2;
  localparam sel_t SEL_ZP = 3'd3;
  localparam sel_t SEL_ZM = 3'd4;

  // Face codes
  localparam logic [FACE_W-1:0] FACE_XP = 3'd0;
  localparam logic [FACE_W-1:0] FACE_XM = 3'd1;
  localparam logic [FACE_W-1:0] FACE_YP = 3'd2;
  localparam logic [FACE_W-1:0] FACE_YM = 3'd3;
  localparam logic [FACE_W-1:0] FACE_ZP = 3'd4;
  localparam logic [FACE_W-1:0] FACE_ZM = 3'd5;

  // Corner codes
  localparam logic [CORN_W-1:0] CORN_P0 = 2'd0;
  localparam logic [CORN_W-1:0] CORN_P1 = 2'd1;
  localparam logic [CORN_W-1:0] CORN_N0 = 2'd2;
  localparam logic [CORN_W-1:0] CORN_N1 = 2'd3;

  // Small signed vector, components in -1..1
  typedef struct packed {
    logic signed [1:0] a;
    logic signed [1:0] b;
    logic signed [1:0] c;
  } vec3_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr;
    logic rd_en;
    sel_t rd_sel;
    logic wb;
    logic emit_init;
    logic emit_step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic kind;
    logic in_range;
    logic center;
    logic any_exposed;
    logic fin;
    logic clr_done;
  } stat_t;

  function automatic vec3_t face_normal(input logic [FACE_W-1:0] f);
    vec3_t v;
    v = '0;
    case (f)
      FACE_XP: v.a = 2'sd1;
      FACE_XM: v.a = -2'sd1;
      FACE_YP: v.b = 2'sd1;
      FACE_YM: v.b = -2'sd1;
      FACE_ZP: v.c = 2'sd1;
      FACE_ZM: v.c = -2'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // p0 = n x ex + n x ey + n x ez, p1 = n x p0; corners p0, p1, -p0, -p1
  function automatic vec3_t corner_offset(input logic [FACE_W-1:0] f,
                                          input logic [CORN_W-1:0] k);
    vec3_t nv;
    vec3_t r;
    int na, nb, nc;
    int p0a, p0b, p0c;
    int p1a, p1b, p1c;
    int ra, rb, rc;
    nv  = face_normal(f);
    na  = int'(nv.a);
    nb  = int'(nv.b);
    nc  = int'(nv.c);
    p0a = nb - nc;
    p0b = nc - na;
    p0c = na - nb;
    p1a = nb * p0c - p0b * nc;
    p1b = nc * p0a - p0c * na;
    p1c = na * p0b - p0a * nb;
    case (k)
      CORN_P0: begin ra = p0a;  rb = p0b;  rc = p0c;  end
      CORN_P1: begin ra = p1a;  rb = p1b;  rc = p1c;  end
      CORN_N0: begin ra = -p0a; rb = -p0b; rc = -p0c; end
      default: begin ra = -p1a; rb = -p1b; rc = -p1c; end
    endcase
    r.a = 2'(ra);
    r.b = 2'(rb);
    r.c = 2'(rc);
    return r;
  endfunction

endpackage

// ----- hw/rtl/vfm_divc.sv -----
// Two-stage divider of a cell address by a constant: reciprocal multiply, one correction.
module vfm_divc #(
  parameter int D = 16
) (
  input  logic                        clk,
  input  logic [vfm_pkg::NUM_W-1:0]   num,
  output logic [vfm_pkg::NUM_W-1:0]   quot,
  output logic [vfm_pkg::NUM_W-1:0]   rem
);

  localparam int NW = vfm_pkg::NUM_W;
  localparam int S  = 16;
  localparam int M  = (1 << S) / D;

  logic [NW+S-1:0] prod;
  logic [NW-1:0]   q0_r;
  logic [NW-1:0]   num_r;
  logic [NW-1:0]   qd;
  logic [NW-1:0]   r0;
  logic            fix;
  logic [NW-1:0]   quot_r;
  logic [NW-1:0]   rem_r;

  // Stage 1: estimate, never above the true quotient and at most one below
  assign prod = (NW+S)'(num) * (NW+S)'(M);

  always_ff @(posedge clk) begin
    q0_r  <= prod[NW+S-1:S];
    num_r <= num;
  end

  // Stage 2: remainder and single correction step
  assign qd  = q0_r * NW'(D);
  assign r0  = num_r - qd;
  assign fix = (r0 >= NW'(D));

  always_ff @(posedge clk) begin
    quot_r <= fix ? q0_r + NW'(1) : q0_r;
    rem_r  <= fix ? r0 - NW'(D) : r0;
  end

  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/vfm_dp.sv -----
// Datapath: item registers, address decode, solid map rows, neighbor capture, vertex output.
module vfm_dp #(
  parameter int CHUNK_EDGE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vfm_pkg::cmd_t                       cmd,
  output vfm_pkg::stat_t                      st,
  input  logic                                in_kind,
  input  logic [vfm_pkg::NUM_W-1:0]           in_cell_index,
  input  logic                                in_solid,
  output logic                                out_valid,
  output logic [vfm_pkg::VN_W-1:0]            out_vertex_number,
  output logic [vfm_pkg::FACE_W-1:0]          out_face_dir,
  output logic [vfm_pkg::CORN_W-1:0]          out_corner,
  output logic signed [vfm_pkg::POS_W-1:0]    out_pos_x2,
  output logic signed [vfm_pkg::POS_W-1:0]    out_pos_y2,
  output logic signed [vfm_pkg::POS_W-1:0]    out_pos_z2,
  output logic [vfm_pkg::COL_W-1:0]           out_col_r2,
  output logic [vfm_pkg::COL_W-1:0]           out_col_g2,
  output logic [vfm_pkg::COL_W-1:0]           out_col_b2,
  output logic                                out_last
);

  localparam int E     = CHUNK_EDGE;
  localparam int ROWS  = E * E;
  localparam int CELLS = ROWS * E;
  localparam int RAW   = $clog2(ROWS);
  localparam int CW    = $clog2(E);
  localparam int NW    = vfm_pkg::NUM_W;
  localparam int NF    = vfm_pkg::NUM_FACES;

  // Latched item
  logic          kind_r;
  logic [NW-1:0] idx_r;
  logic          solid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      idx_r   <= in_cell_index;
      solid_r <= in_solid;
    end
  end

  // Address decode: idx = row*E + y, row = z*E + x
  logic [NW-1:0] q1, r1, q2, r2;

  vfm_divc #(.D(E)) u_div_row (
    .clk  (clk),
    .num  (idx_r),
    .quot (q1),
    .rem  (r1)
  );

  vfm_divc #(.D(E)) u_div_col (
    .clk  (clk),
    .num  (q1),
    .quot (q2),
    .rem  (r2)
  );

  logic [RAW-1:0] row;
  logic [CW-1:0]  y, x, z;
  logic           in_range;

  assign row      = q1[RAW-1:0];
  assign y        = r1[CW-1:0];
  assign x        = r2[CW-1:0];
  assign z        = q2[CW-1:0];
  assign in_range = (int'(idx_r) < CELLS);

  // Read address of the selected row and whether that row lies inside the chunk
  logic [RAW-1:0] rd_addr;
  logic           rd_inb;

  always_comb begin
    unique case (cmd.rd_sel)
      vfm_pkg::SEL_C: begin
        rd_addr = row;
        rd_inb  = 1'b1;
      end
      vfm_pkg::SEL_XP: begin
        rd_addr = row + RAW'(1);
        rd_inb  = (x != CW'(E - 1));
      end
      vfm_pkg::SEL_XM: begin
        rd_addr = row - RAW'(1);
        rd_inb  = (x != '0);
      end
      vfm_pkg::SEL_ZP: begin
        rd_addr = row + RAW'(E);
        rd_inb  = (z != CW'(E - 1));
      end
      vfm_pkg::SEL_ZM: begin
        rd_addr = row - RAW'(E);
        rd_inb  = (z != '0);
      end
      default: begin
        rd_addr = row;
        rd_inb  = 1'b0;
      end
    endcase
  end

  // Clear sweep counter, one row per cycle after reset
  logic [RAW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + RAW'(1);
    end
  end

  // Solid map: one row of E cells (all y) per entry
  logic [E-1:0]   mem [ROWS];
  logic [E-1:0]   rd_data_r;
  logic [E-1:0]   wr_merge;
  logic           wr_en;
  logic [RAW-1:0] wr_addr;
  logic [E-1:0]   wr_data;

  always_comb begin
    for (int i = 0; i < E; i++) begin
      wr_merge[i] = (CW'(i) == y) ? solid_r : rd_data_r[i];
    end
  end

  assign wr_en   = cmd.clr | (cmd.wb & in_range);
  assign wr_addr = cmd.clr ? clr_r : row;
  assign wr_data = cmd.clr ? '0 : wr_merge;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Tag travels with each read so the returning row lands in the right place
  logic                tag_vld_r;
  vfm_pkg::sel_t       tag_r;
  logic                tag_inb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      tag_r     <= cmd.rd_sel;
      tag_inb_r <= rd_inb;
    end
  end

  // Neighbor capture: solid bits in face order +x,-x,+y,-y,+z,-z
  logic          ctr_r;
  logic [NF-1:0] nbs_r;
  logic          bit_c, bit_yp, bit_ym;

  assign bit_c  = rd_data_r[y];
  assign bit_yp = (y != CW'(E - 1)) ? rd_data_r[y + CW'(1)] : 1'b0;
  assign bit_ym = (y != '0) ? rd_data_r[y - CW'(1)] : 1'b0;

  always_ff @(posedge clk) begin
    if (tag_vld_r) begin
      case (tag_r)
        vfm_pkg::SEL_C: begin
          ctr_r    <= bit_c;
          nbs_r[2] <= bit_yp;
          nbs_r[3] <= bit_ym;
        end
        vfm_pkg::SEL_XP: nbs_r[0] <= tag_inb_r & bit_c;
        vfm_pkg::SEL_XM: nbs_r[1] <= tag_inb_r & bit_c;
        vfm_pkg::SEL_ZP: nbs_r[4] <= tag_inb_r & bit_c;
        vfm_pkg::SEL_ZM: nbs_r[5] <= tag_inb_r & bit_c;
        default: ;
      endcase
    end
  end

  // Face walk: hit on an exposed face, and whether any exposed face follows it
  logic [NF-1:0]               exposed;
  logic [vfm_pkg::FACE_W-1:0]  face_r;
  logic [vfm_pkg::CORN_W-1:0]  corner_r;
  logic                        hit;
  logic                        any_above;
  logic                        fin;

  assign exposed = ~nbs_r;

  always_comb begin
    hit       = 1'b0;
    any_above = 1'b0;
    for (int i = 0; i < NF; i++) begin
      if (face_r == vfm_pkg::FACE_W'(i)) hit = exposed[i];
      if (vfm_pkg::FACE_W'(i) > face_r) any_above = any_above | exposed[i];
    end
  end

  assign fin = hit && (corner_r == vfm_pkg::CORN_N1) && !any_above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_r   <= '0;
      corner_r <= '0;
    end else if (cmd.emit_init) begin
      face_r   <= '0;
      corner_r <= '0;
    end else if (cmd.emit_step) begin
      if (hit) begin
        corner_r <= corner_r + vfm_pkg::CORN_W'(1);
        if (corner_r == vfm_pkg::CORN_N1) face_r <= face_r + vfm_pkg::FACE_W'(1);
      end else begin
        face_r <= face_r + vfm_pkg::FACE_W'(1);
      end
    end
  end

  // Running vertex count: cleared by writes, bumped per vertex
  logic [vfm_pkg::VN_W-1:0] vcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
    end else if (cmd.wb) begin
      vcnt_r <= '0;
    end else if (cmd.emit_step && hit) begin
      vcnt_r <= vcnt_r + vfm_pkg::VN_W'(1);
    end
  end

  // Vertex geometry in half units: 2*cell + n + p
  vfm_pkg::vec3_t nv, po;
  logic [7:0]     px, py, pz;

  assign nv = vfm_pkg::face_normal(face_r);
  assign po = vfm_pkg::corner_offset(face_r, corner_r);
  assign px = (8'(x) << 1) + 8'(nv.a) + 8'(po.a);
  assign py = (8'(y) << 1) + 8'(nv.b) + 8'(po.b);
  assign pz = (8'(z) << 1) + 8'(nv.c) + 8'(po.c);

  // Output register, one strobe per vertex
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_step && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step && hit) begin
      out_vertex_number <= vcnt_r;
      out_face_dir      <= face_r;
      out_corner        <= corner_r;
      out_pos_x2        <= px[vfm_pkg::POS_W-1:0];
      out_pos_y2        <= py[vfm_pkg::POS_W-1:0];
      out_pos_z2        <= pz[vfm_pkg::POS_W-1:0];
      out_col_r2        <= 2'(nv.a) + 2'd1;
      out_col_g2        <= 2'(nv.b) + 2'd1;
      out_col_b2        <= 2'(nv.c) + 2'd1;
      out_last          <= fin;
    end
  end

  assign out_valid = out_valid_r;

  // Status back to the controller
  always_comb begin
    st.kind        = kind_r;
    st.in_range    = in_range;
    st.center      = ctr_r;
    st.any_exposed = |exposed;
    st.fin         = fin;
    st.clr_done    = (clr_r == RAW'(ROWS - 1));
  end

  // Every strobe comes from a step of the face walk
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.emit_step))
    else $error("vertex strobe without an emit step");

  // Nothing follows the final vertex of an item directly
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last |=> !out_valid_r)
    else $error("vertex strobe right after a last vertex");

  // Back-to-back vertices of one item carry consecutive numbers
  a_vn_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && $past(out_valid_r) && !$past(out_last) |->
      out_vertex_number == $past(out_vertex_number) + vfm_pkg::VN_W'(1))
    else $error("vertex numbers not consecutive");

endmodule

// ----- hw/rtl/vfm_ctrl.sv -----
// Controller: sequences clear sweep, decode wait, map reads, write-back and face walk.
module vfm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  vfm_pkg::stat_t  st,
  output vfm_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_CAP   = 3'd5;
  localparam logic [2:0] S_EVAL  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam logic [2:0] DEC_LAST = 3'd3;
  localparam logic [2:0] RD_LAST  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DEC;
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_DEC: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == DEC_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (st.kind == vfm_pkg::KIND_WRITE) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = vfm_pkg::SEL_C;
          state_nxt  = S_WB;
        end else if (!st.in_range) begin
          state_nxt = S_IDLE;
        end else begin
          // selectors are numbered in read order, center row first
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = cnt_r;
          cnt_nxt    = cnt_r + 3'd1;
          if (cnt_r == RD_LAST) state_nxt = S_CAP;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CAP: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (st.center && st.any_exposed) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd.emit_step = 1'b1;
        if (st.fin) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // An idle block issues no map or emit traffic
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !cmd.rd_en && !cmd.emit_step && !cmd.wb && !cmd.clr)
    else $error("map or emit command while idle");

  // A map write-back always follows the read of its row
  a_wb_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> $past(cmd.rd_en) && $past(cmd.rd_sel) == vfm_pkg::SEL_C)
    else $error("write-back without a preceding row read");

  // An accepted item is never taken during the clear sweep
  a_no_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $past(state_r) != S_CLEAR || $past(st.clr_done))
    else $error("item accepted before the clear sweep finished");

endmodule

// ----- hw/rtl/voxel_face_mesher.sv -----
// Top level of the voxel face mesher: controller plus datapath.
//
// Command-style input: an item is taken at a clock edge with start high and
// busy low. in_kind selects a cell write (0) or a cell mesh (1).
// Results come out one vertex per strobe: out_valid is high for exactly one
// cycle per vertex and the receiver takes it then; it cannot stall the block.
// out_last marks the final vertex of a mesh item.
// After reset the block sweeps the solid map to air, one row of CHUNK_EDGE
// cells per cycle, all CHUNK_EDGE*CHUNK_EDGE rows (256 at the default size);
// busy stays high during the sweep. The vertex count resets to zero.
// A write item keeps busy high through address decode, a row read and the
// row write-back, and gives no result.
// A mesh item passes through address decode, five single-port row reads,
// capture and evaluation, then the face walk, which takes one vertex or
// one skipped face at a time up to the last exposed face.
// The single map read port and one vertex per cycle set the rate.
// busy drops while the final vertex is still on the result ports.
module voxel_face_mesher #(
  parameter int CHUNK_EDGE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic [vfm_pkg::NUM_W-1:0]           in_cell_index,
  input  logic                                in_solid,
  output logic                                out_valid,
  output logic [vfm_pkg::VN_W-1:0]            out_vertex_number,
  output logic [vfm_pkg::FACE_W-1:0]          out_face_dir,
  output logic [vfm_pkg::CORN_W-1:0]          out_corner,
  output logic signed [vfm_pkg::POS_W-1:0]    out_pos_x2,
  output logic signed [vfm_pkg::POS_W-1:0]    out_pos_y2,
  output logic signed [vfm_pkg::POS_W-1:0]    out_pos_z2,
  output logic [vfm_pkg::COL_W-1:0]           out_col_r2,
  output logic [vfm_pkg::COL_W-1:0]           out_col_g2,
  output logic [vfm_pkg::COL_W-1:0]           out_col_b2,
  output logic                                out_last
);

  vfm_pkg::cmd_t  cmd;
  vfm_pkg::stat_t st;

  // Sequencer
  vfm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // Map, decode and vertex generation
  vfm_dp #(.CHUNK_EDGE(CHUNK_EDGE)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_kind           (in_kind),
    .in_cell_index     (in_cell_index),
    .in_solid          (in_solid),
    .out_valid         (out_valid),
    .out_vertex_number (out_vertex_number),
    .out_face_dir      (out_face_dir),
    .out_corner        (out_corner),
    .out_pos_x2        (out_pos_x2),
    .out_pos_y2        (out_pos_y2),
    .out_pos_z2        (out_pos_z2),
    .out_col_r2        (out_col_r2),
    .out_col_g2        (out_col_g2),
    .out_col_b2        (out_col_b2),
    .out_last          (out_last)
  );

endmodule
